// ===== rtl/core/tsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared constants and codes for the two-stack shared-memory block.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int DATA_W        = 32;
	localparam int CAP_W         = 6;
	localparam int STORE_DEPTH_D = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/tsm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/two_stacks_shared_memory.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_stacks_shared_memory
// Two LIFO stacks of signed 32-bit words sharing one RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on the s_axis channel: tuser carries the operation and the
//    stack select, tdata the word to push. Stack one grows up from entry 0,
//    stack two grows down from the top of the capacity in use.
//  - Every request yields exactly one result on the m_axis channel: the popped
//    or peeked word, a status code in tuser and both stack sizes after it.
//  - The result is registered and appears in the cycle after the input transfer;
//    one request per cycle is sustained while the receiver takes results. Each
//    request does one write or one read on the single RAM port pair, issued at
//    the input transfer, with the read data landing in the RAM output register.
//  - When the receiver stalls, the result holds in the output stage and
//    s_axis_tready drops until it is taken.
//  - cfg_we writes the capacity and empties both stacks; write it only while
//    no result is outstanding.
//  - Reset clears both sizes, sets the capacity to 32 and drops any pending
//    result. RAM contents are not cleared.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory #(
	parameter int STORE_DEPTH = tsm_pkg::STORE_DEPTH_D
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_we,
	input  wire logic [tsm_pkg::CAP_W-1:0]  cfg_wdata,     // capacity_in_use
	// requests
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [31:0]                s_axis_tdata,  // [31:0] push_data
	input  wire logic [2:0]                 s_axis_tuser,  // [1:0] req_type, [2] stack_sel
	// results
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic      [47:0]                m_axis_tdata,  // [31:0] read_data,
	                                                       // [37:32] size_one,
	                                                       // [43:38] size_two, pad
	output logic      [1:0]                 m_axis_tuser   // [1:0] status
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IW = (AW > tsm_pkg::CAP_W) ? AW : tsm_pkg::CAP_W;
	localparam int CW = tsm_pkg::CAP_W;

	logic [CW-1:0] cap_q;
	logic [CW-1:0] count_one_q;
	logic [CW-1:0] count_two_q;

	logic          valid_s1;
	logic          rd_s1;
	logic [1:0]    status_s1;

	logic [CW-1:0] cap_eff;
	logic          accept;
	logic [1:0]    req_type;
	logic          stack_sel;
	logic [CW:0]   count_sum;
	logic [CW-1:0] idx;
	logic [IW-1:0] idx_w;
	logic [AW-1:0] addr;
	logic          ram_we;
	logic          ram_re;
	logic [1:0]    status_nxt;
	logic [CW-1:0] count_one_nxt;
	logic [CW-1:0] count_two_nxt;
	logic [tsm_pkg::DATA_W-1:0] ram_rdata;

	assign req_type  = s_axis_tuser[1:0];
	assign stack_sel = s_axis_tuser[2];

	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// a capacity above the store is clamped to the store
	always_comb begin
		if (32'(cap_q) > STORE_DEPTH) begin
			cap_eff = CW'(STORE_DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign count_sum = {1'b0, count_one_q} + {1'b0, count_two_q};

	always_comb begin
		status_nxt    = tsm_pkg::ST_OK;
		count_one_nxt = count_one_q;
		count_two_nxt = count_two_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		idx           = '0;
		unique case (req_type)
			tsm_pkg::REQ_PUSH: begin
				if (count_sum >= {1'b0, cap_eff}) begin
					status_nxt = tsm_pkg::ST_FULL;
				end else if (!stack_sel) begin
					idx           = count_one_q;
					ram_we        = accept;
					count_one_nxt = count_one_q + 1'b1;
				end else begin
					idx           = cap_eff - count_two_q - 1'b1;
					ram_we        = accept;
					count_two_nxt = count_two_q + 1'b1;
				end
			end
			tsm_pkg::REQ_POP, tsm_pkg::REQ_PEEK: begin
				if ((stack_sel ? count_two_q : count_one_q) == '0) begin
					status_nxt = tsm_pkg::ST_EMPTY;
				end else begin
					idx    = stack_sel ? (cap_eff - count_two_q) : (count_one_q - 1'b1);
					ram_re = accept;
					if (req_type == tsm_pkg::REQ_POP) begin
						if (stack_sel) begin
							count_two_nxt = count_two_q - 1'b1;
						end else begin
							count_one_nxt = count_one_q - 1'b1;
						end
					end
				end
			end
			default: begin
				// unused code: no change, plain answer
			end
		endcase
	end

	assign idx_w = IW'(idx);
	assign addr  = idx_w[AW-1:0];

	tsm_ram #(
		.WIDTH(tsm_pkg::DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(s_axis_tdata),
		.re   (ram_re),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= tsm_pkg::CAP_RESET;
			count_one_q <= '0;
			count_two_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				// new capacity empties both stacks
				cap_q       <= cfg_wdata;
				count_one_q <= '0;
				count_two_q <= '0;
			end else if (accept) begin
				count_one_q <= count_one_nxt;
				count_two_q <= count_two_nxt;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= ram_re;
			status_s1 <= status_nxt;
		end
	end

	// sizes after the request are the live counters until the next transfer
	assign m_axis_tvalid = valid_s1;
	assign m_axis_tuser  = status_s1;
	assign m_axis_tdata  = {4'b0, count_two_q, count_one_q,
	                        (rd_s1 ? ram_rdata : {tsm_pkg::DATA_W{1'b0}})};

`ifndef SYNTHESIS
	a_sum_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_sum <= {1'b0, cap_eff})
		else $error("stack sizes exceed capacity");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 == tsm_pkg::ST_FULL) |-> (count_sum == {1'b0, cap_eff}))
		else $error("push refused while space left");

	a_pop_one_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we && req_type == tsm_pkg::REQ_POP && !stack_sel
		 && count_one_q != '0)
		|=> (count_one_q == $past(count_one_q) - 1'b1))
		else $error("pop did not shrink stack one");

	a_read_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rd_s1) |-> (status_s1 == tsm_pkg::ST_OK))
		else $error("read data returned with error status");
`endif

endmodule
`default_nettype wire

// ===== bench/two_stacks_shared_memory_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_stacks_shared_memory_test
// Self-checking bench for the two-stack shared-memory block. Push, pop and
// peek requests go to both stacks under many capacity settings, with random
// gaps on the request side and random stalls on the result side. A scoreboard
// keeps its own copy of both stacks and checks every result field by field.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory_test;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RANDOM_REQS = 1400;
	localparam int         MAX_REPORTS = 10;

	typedef struct packed {
		logic [tsm_pkg::DATA_W-1:0] read_data;
		logic [1:0]                 status;
		logic [tsm_pkg::CAP_W-1:0]  size_one;
		logic [tsm_pkg::CAP_W-1:0]  size_two;
	} stack_result_t;

	typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// Mirror of both stacks; predicts one result per accepted request.
	class stack_scoreboard;
		logic [tsm_pkg::DATA_W-1:0] words [tsm_pkg::STORE_DEPTH_D];
		int                         depth_one;
		int                         depth_two;
		logic [tsm_pkg::CAP_W-1:0]  capacity;
		stack_result_t              expected_q [$];
		int                         errors;

		function new();
			foreach (words[i]) words[i] = '0;
			depth_one = 0;
			depth_two = 0;
			capacity  = tsm_pkg::CAP_RESET;
			errors    = 0;
		endfunction

		function void set_capacity(logic [tsm_pkg::CAP_W-1:0] value);
			capacity  = value;
			depth_one = 0;
			depth_two = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic [1:0] req, logic sel,
			logic [tsm_pkg::DATA_W-1:0] data);
			stack_result_t res;
			int            usable;
			int            held;
			int            slot;
			usable = (capacity > tsm_pkg::STORE_DEPTH_D) ? tsm_pkg::STORE_DEPTH_D
			                                              : int'(capacity);
			res.read_data = '0;
			res.status    = tsm_pkg::ST_OK;
			if (req == tsm_pkg::REQ_PUSH) begin
				if (depth_one + depth_two >= usable) begin
					res.status = tsm_pkg::ST_FULL;
				end else if (!sel) begin
					words[depth_one] = data;
					depth_one++;
				end else begin
					words[usable - depth_two - 1] = data;
					depth_two++;
				end
			end else if (req == tsm_pkg::REQ_POP || req == tsm_pkg::REQ_PEEK) begin
				held = sel ? depth_two : depth_one;
				if (held == 0 || held > usable) begin
					res.status = tsm_pkg::ST_EMPTY;
				end else begin
					slot = sel ? (usable - depth_two) : (depth_one - 1);
					res.read_data = words[slot];
					if (req == tsm_pkg::REQ_POP) begin
						if (sel) depth_two--;
						else depth_one--;
					end
				end
			end
			res.size_one = depth_one[tsm_pkg::CAP_W-1:0];
			res.size_two = depth_two[tsm_pkg::CAP_W-1:0];
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [47:0] data, logic [1:0] user);
			stack_result_t want;
			stack_result_t got;
			got.read_data = data[31:0];
			got.size_one  = data[37:32];
			got.size_two  = data[43:38];
			got.status    = user;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: data %h status %0d sizes %0d/%0d",
						got.read_data, got.status, got.size_one, got.size_two);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"mismatch: expected data %h status %0d sizes %0d/%0d,",
						" got data %h status %0d sizes %0d/%0d"},
						want.read_data, want.status, want.size_one, want.size_two,
						got.read_data, got.status, got.size_one, got.size_two);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [tsm_pkg::CAP_W-1:0] cfg_wdata;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [31:0]               s_axis_tdata;   // [31:0] push_data
	logic [2:0]                s_axis_tuser;   // [1:0] req_type, [2] stack_sel
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [47:0]               m_axis_tdata;   // [31:0] read_data, [37:32] size_one,
	                                           // [43:38] size_two
	logic [1:0]                m_axis_tuser;   // [1:0] status

	stack_scoreboard sb = new();
	int              cycle_count = 0;
	int              rx_count = 0;
	rx_mode_t        rx_mode = RX_STEADY;
	int              burst_left = 0;

	two_stacks_shared_memory DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("two_stacks_shared_memory regression: fail");
			$finish;
		end
	end

	// Result side stalls: the stall pattern is picked anew at random as rx_count runs.
	always @(posedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_count % 64 == 0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_STEADY:   m_axis_tready <= 1'b1;
			RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= rx_count[2];
		endcase
	end

	// Check results first: a result at this edge belongs to an earlier request.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if (s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tdata);
	end

	task automatic send_request(input logic [1:0] req, input logic sel,
		input logic [31:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= {sel, req};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Same as send_request, but inserts idle gaps between random bursts.
	task automatic offer_request(input logic [1:0] req, input logic sel,
		input logic [31:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_request(req, sel, data);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [tsm_pkg::CAP_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_capacity(value);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [tsm_pkg::CAP_W-1:0] pick_capacity();
		case ($urandom_range(0, 11))
			0:       return 6'd0;
			1:       return 6'd1;
			2:       return 6'd32;
			3:       return 6'd63;
			4:       return 6'($urandom_range(33, 62));
			5:       return 6'($urandom_range(9, 31));
			default: return 6'($urandom_range(2, 8));
		endcase
	endfunction

	initial begin
		int          sent;
		int          phase_len;
		int          mix_left;
		int          push_pct;
		int          r;
		logic [1:0]  req;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, both stacks, reset capacity.
		send_request(tsm_pkg::REQ_PUSH, 1'b0, 32'h7FFF_FFFF);
		send_request(tsm_pkg::REQ_PUSH, 1'b1, 32'h8000_0000);
		send_request(tsm_pkg::REQ_PEEK, 1'b0, 32'h0);
		send_request(tsm_pkg::REQ_PEEK, 1'b1, 32'h0);
		send_request(tsm_pkg::REQ_POP, 1'b0, 32'hFFFF_FFFF);
		send_request(tsm_pkg::REQ_POP, 1'b1, 32'h0);
		send_request(tsm_pkg::REQ_POP, 1'b0, 32'h0);
		send_request(tsm_pkg::REQ_PEEK, 1'b1, 32'h0);
		send_request(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF);
		send_request(tsm_pkg::REQ_PUSH, 1'b0, 32'hFFFF_FFFF);
		send_request(tsm_pkg::REQ_PUSH, 1'b1, 32'h0);
		send_request(REQ_UNUSED, 1'b0, 32'h0);
		// Capacity one: second push refused as full.
		write_capacity(6'd1);
		send_request(tsm_pkg::REQ_PUSH, 1'b1, 32'h1234_5678);
		send_request(tsm_pkg::REQ_PUSH, 1'b0, 32'hDEAD_BEEF);
		send_request(tsm_pkg::REQ_PEEK, 1'b0, 32'h0);
		send_request(tsm_pkg::REQ_POP, 1'b1, 32'h0);
		// Capacity zero: always full and always empty.
		write_capacity(6'd0);
		send_request(tsm_pkg::REQ_PUSH, 1'b0, 32'h5555_5555);
		send_request(tsm_pkg::REQ_POP, 1'b1, 32'h0);
		send_request(tsm_pkg::REQ_PEEK, 1'b0, 32'h0);
		// Capacity above the store clamps to the store depth.
		write_capacity(6'd63);
		send_request(tsm_pkg::REQ_PUSH, 1'b1, 32'hAAAA_AAAA);
		send_request(tsm_pkg::REQ_PUSH, 1'b0, 32'h0000_0001);
		send_request(tsm_pkg::REQ_POP, 1'b1, 32'h0);
		send_request(tsm_pkg::REQ_POP, 1'b0, 32'h0);

		// Random phases: new capacity, then shifting push/pop mixes.
		sent = 0;
		while (sent < RANDOM_REQS) begin
			write_capacity(pick_capacity());
			phase_len = $urandom_range(30, 120);
			mix_left  = 0;
			push_pct  = 50;
			repeat (phase_len) begin
				if (mix_left == 0) begin
					push_pct = $urandom_range(15, 90);
					mix_left = $urandom_range(8, 24);
				end
				mix_left--;
				r = $urandom_range(0, 99);
				if (r < 3)
					req = REQ_UNUSED;
				else if (r < push_pct)
					req = tsm_pkg::REQ_PUSH;
				else if (r % 4 == 0)
					req = tsm_pkg::REQ_PEEK;
				else
					req = tsm_pkg::REQ_POP;
				offer_request(req, 1'($urandom_range(0, 1)), pick_word());
				sent++;
			end
		end

		drain_results();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("two_stacks_shared_memory regression: pass");
		else
			$display("two_stacks_shared_memory regression: fail");
		$finish;
	end

endmodule
